// File: rtl/fifo_page_replacement_core_assert.svh
// ----------------------------------------------------------------------------
// fifo page replacement assertion macros
// concurrent checks on clk_i, with and without the reset disable
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FPR_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FPR_ASSERT(lbl, prop, msg)
`define FPR_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// File: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// shared types and constants of the fifo page replacement core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int unsigned ADDR_W          = 31;
  localparam int unsigned PSIZE_W         = 21;
  localparam int unsigned FCNT_W          = 5;
  localparam int unsigned FAULT_W         = 32;
  localparam int unsigned SLOT_OUT_W      = 4;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam int unsigned DIV_CNT_W       = $clog2(ADDR_W + 1);
  localparam int unsigned MAX_FRAMES_DEF  = 16;

  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = PSIZE_W'(4096);
  localparam logic [FCNT_W-1:0]  FRAME_COUNT_RST = FCNT_W'(16);

  typedef enum logic [0:0] {
    REG_PAGE_SIZE   = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MATCH,
    ST_RESOLVE
  } state_e;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [PSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/fifo_page_replacement_core.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_core
// page lookup with fifo replacement over a fully associative frame table
// ----------------------------------------------------------------------------
// usage
//   input channel: address_i with in_valid_i / in_ready_o; a transaction
//   happens when both are high. in_ready_o is high only while the core is
//   idle, so one address is worked on at a time.
//   output channel: page_number_o, hit_o, slot_o, fault_count_o with
//   out_valid_o / out_ready_i. results sit in an output register, so the next
//   address is taken while a finished result still waits.
//   config: apb-style port, page_size at 0x0, frame_count at 0x4, pready is
//   always high; write only while no address is in flight.
// sequence
//   per address: the accept, 31 divider steps (one quotient bit each), the
//   check that the divider is done, the parallel frame compare and the
//   resolve that updates the table. the resolve sets out_valid_o when it
//   loads the output register; no new address is taken before the resolve.
// reset
//   valid bits, replacement pointer and fault total clear, registers return
//   to page_size 4096 and frame_count 16. frame contents are not cleared.
// stall
//   if the receiver holds out_ready_i low, the next result waits in the
//   resolve step and the table is not updated until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_page_replacement_core_assert.svh"

module fifo_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // address channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fpr_pkg::ADDR_W-1:0]     address_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fpr_pkg::ADDR_W-1:0]     page_number_o,
  output logic                           hit_o,
  output logic [fpr_pkg::SLOT_OUT_W-1:0] slot_o,
  output logic [fpr_pkg::FAULT_W-1:0]    fault_count_o,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpr_pkg::PADDR_W-1:0]    paddr,
  input  logic [fpr_pkg::PDATA_W-1:0]    pwdata,
  output logic [fpr_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import fpr_pkg::*;

  localparam int unsigned SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  // compare width covers both the frame count register and the table depth
  localparam int unsigned CMP_W  = ((CNT_W > FCNT_W) ? CNT_W : FCNT_W) + 1;
  localparam int unsigned SX_W   = SLOT_W + SLOT_OUT_W;

  // config registers
  logic [PSIZE_W-1:0] psize_q, psize_d;
  logic [FCNT_W-1:0]  fcnt_q, fcnt_d;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  // frame table and replacement state
  logic [ADDR_W-1:0]     pages_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]     next_slot_q, next_slot_d;
  logic [FAULT_W-1:0]    faults_q, faults_d;
  logic [MAX_FRAMES-1:0] match_q, match_d;

  // sequencer
  state_e state_q, state_d;
  logic   div_start, match_en, res_go;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     page_out_q;
  logic                  hit_out_q;
  logic [SLOT_OUT_W-1:0] slot_out_q;
  logic [FAULT_W-1:0]    fault_out_q;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // resolve logic
  logic [CMP_W-1:0]  fcnt_ext, n_ext, fill_p1;
  logic              res_hit;
  logic [SLOT_W-1:0] hit_slot, fill_slot, res_slot;
  logic [SX_W-1:0]   slot_wide;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    psize_d = psize_q;
    fcnt_d  = fcnt_q;
    prdata  = '0;
    unique case (reg_idx)
      REG_PAGE_SIZE: begin
        prdata = PDATA_W'(psize_q);
        if (cfg_wr) begin
          psize_d = pwdata[PSIZE_W-1:0];
        end
      end
      REG_FRAME_COUNT: begin
        prdata = PDATA_W'(fcnt_q);
        if (cfg_wr) begin
          fcnt_d = pwdata[FCNT_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= PAGE_SIZE_RST;
      fcnt_q  <= FRAME_COUNT_RST;
    end else begin
      psize_q <= psize_d;
      fcnt_q  <= fcnt_d;
    end
  end

  // frames in use: zero counts as one, clamp at the table depth
  always_comb begin
    fcnt_ext = CMP_W'(fcnt_q);
    if (fcnt_ext == '0) begin
      n_ext = CMP_W'(1);
    end else if (fcnt_ext > CMP_W'(MAX_FRAMES)) begin
      n_ext = CMP_W'(MAX_FRAMES);
    end else begin
      n_ext = fcnt_ext;
    end
  end

  // ---------------------------------------------------------------- divider
  // page size zero divides by one
  assign div_req.start    = div_start;
  assign div_req.dividend = address_i;
  assign div_req.divisor  = (psize_q == '0) ? PSIZE_W'(1) : psize_q;

  fpr_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_rsp.busy) begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    match_en   = 1'b0;
    res_go     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i;
      end
      ST_DIV:     ;
      ST_MATCH:   match_en = 1'b1;
      ST_RESOLVE: res_go = !out_valid_q || out_ready_i;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- match
  // every frame compares in its own lane, masked by valid and frames in use
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match_d[i] = valid_q[i] && (pages_q[i] == div_rsp.quotient)
                   && (CMP_W'(i) < n_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (match_en) begin
      match_q <= match_d;
    end
  end

  // ---------------------------------------------------------------- resolve
  // lowest matching frame wins
  always_comb begin
    res_hit  = 1'b0;
    hit_slot = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        res_hit  = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // pointer outside the frames in use falls back to frame zero
  always_comb begin
    fill_slot = (CMP_W'(next_slot_q) < n_ext) ? next_slot_q : '0;
    fill_p1   = CMP_W'(fill_slot) + CMP_W'(1);
    res_slot  = res_hit ? hit_slot : fill_slot;
    slot_wide = SX_W'(res_slot);
  end

  always_comb begin
    valid_d     = valid_q;
    next_slot_d = next_slot_q;
    faults_d    = faults_q;
    if (res_go && !res_hit) begin
      valid_d[fill_slot] = 1'b1;
      next_slot_d        = (fill_p1 >= n_ext) ? '0 : fill_p1[SLOT_W-1:0];
      if (faults_q != '1) begin
        faults_d = faults_q + FAULT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      next_slot_q <= '0;
      faults_q    <= '0;
    end else begin
      valid_q     <= valid_d;
      next_slot_q <= next_slot_d;
      faults_q    <= faults_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_go && !res_hit) begin
      pages_q[fill_slot] <= div_rsp.quotient;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_go) begin
      page_out_q  <= div_rsp.quotient;
      hit_out_q   <= res_hit;
      slot_out_q  <= slot_wide[SLOT_OUT_W-1:0];
      fault_out_q <= faults_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign page_number_o = page_out_q;
  assign hit_o         = hit_out_q;
  assign slot_o        = slot_out_q;
  assign fault_count_o = fault_out_q;

  // ---------------------------------------------------------------- checks
  `FPR_ASSERT(a_idle_div_free, (state_q == ST_IDLE) |-> !div_rsp.busy, "divider busy while idle")
  `FPR_ASSERT(a_hit_no_fault, (res_go && res_hit) |=> (faults_q == $past(faults_q)), "hit changed fault total")
  `FPR_ASSERT(a_miss_counts, (res_go && !res_hit) |=> ((faults_q == $past(faults_q) + 32'd1) || (&faults_q)), "fault not counted")
  `FPR_ASSERT(a_result_total, res_go |=> (out_valid_o && (fault_count_o == faults_q)), "result total mismatch")

endmodule

// File: rtl/fpr_divider.sv
// ----------------------------------------------------------------------------
// fpr_divider
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpr_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpr_pkg::div_req_t req_i,
  output fpr_pkg::div_rsp_t rsp_o
);
  import fpr_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PSIZE_W-1:0]   rem_q, rem_d;
  logic [ADDR_W-1:0]    quo_q, quo_d;
  logic [PSIZE_W-1:0]   dvs_q, dvs_d;

  logic [PSIZE_W:0]   trial;
  logic [PSIZE_W+1:0] diff;
  logic               borrow;

  always_comb begin
    trial  = {rem_q, quo_q[ADDR_W-1]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    borrow = diff[PSIZE_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(ADDR_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, keep the difference when it fits
      rem_d = borrow ? trial[PSIZE_W-1:0] : diff[PSIZE_W-1:0];
      quo_d = {quo_q[ADDR_W-2:0], ~borrow};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: tb/fifo_page_replacement_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_core_test
// self-checking bench: directed and random addresses through the core,
// a frame table predictor checks each result, config changes between phases
// ----------------------------------------------------------------------------

module fifo_page_replacement_core_test;
  import fpr_pkg::*;

  // run shape
  localparam int unsigned FRAMES       = MAX_FRAMES_DEF;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 153;
  localparam int unsigned CALM_PHASE   = 4;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned MAX_GAP      = 6;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam longint unsigned MAX_ADDR = 64'h7FFF_FFFF;
  localparam logic [PDATA_W-1:0] PAGE_SIZE_MAX = (1 << PSIZE_W) - 1;

  // one result transaction
  typedef struct packed {
    logic [ADDR_W-1:0]     page_number;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [FAULT_W-1:0]    fault_count;
  } lookup_t;

  // frame table predictor plus queue of lookups still owed by the core
  class frame_table_scoreboard;
    logic [ADDR_W-1:0]  frame_page [FRAMES];
    bit                 frame_valid [FRAMES];
    int unsigned        fifo_hand;
    logic [FAULT_W-1:0] faults;
    logic [PSIZE_W-1:0] page_size;
    logic [FCNT_W-1:0]  frame_count;
    lookup_t            pending_lookups[$];
    int unsigned        mismatches;

    function new();
      page_size   = PAGE_SIZE_RST;
      frame_count = FRAME_COUNT_RST;
      fifo_hand   = 0;
      faults      = '0;
      mismatches  = 0;
      foreach (frame_valid[i]) begin
        frame_valid[i] = 1'b0;
        frame_page[i]  = '0;
      end
    endfunction

    function void write_register(reg_idx_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_PAGE_SIZE:   page_size   = value[PSIZE_W-1:0];
        REG_FRAME_COUNT: frame_count = value[FCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one frame, oversize saturates at the table depth
    function int unsigned frames_active();
      if (frame_count == 0) return 1;
      if (frame_count > FRAMES) return FRAMES;
      return frame_count;
    endfunction

    function int unsigned outstanding();
      return pending_lookups.size();
    endfunction

    function void note_address(logic [ADDR_W-1:0] address);
      logic [ADDR_W-1:0] divisor;
      lookup_t           res;
      int unsigned       n;
      int unsigned       victim;
      divisor = (page_size == 0) ? ADDR_W'(1) : ADDR_W'(page_size);
      n = frames_active();
      res.page_number = address / divisor;
      res.hit = 1'b0;
      victim = 0;
      // lowest matching frame wins
      for (int i = 0; i < n; i++) begin
        if (!res.hit && frame_valid[i] && frame_page[i] == res.page_number) begin
          res.hit = 1'b1;
          victim  = i;
        end
      end
      if (!res.hit) begin
        // a stale pointer past the active frames restarts at frame zero
        victim = (fifo_hand < n) ? fifo_hand : 0;
        frame_page[victim]  = res.page_number;
        frame_valid[victim] = 1'b1;
        fifo_hand = (victim + 1 >= n) ? 0 : victim + 1;
        if (faults != '1) faults = faults + 1;
      end
      res.slot = victim[SLOT_OUT_W-1:0];
      res.fault_count = faults;
      pending_lookups.push_back(res);
    endfunction

    function void compare_lookup(lookup_t got);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: page %0h hit %0b slot %0d faults %0d",
                   got.page_number, got.hit, got.slot, got.fault_count);
        return;
      end
      want = pending_lookups.pop_front();
      if (got.page_number !== want.page_number || got.hit !== want.hit ||
          got.slot !== want.slot || got.fault_count !== want.fault_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: page %0h/%0h hit %0b/%0b slot %0d/%0d faults %0d/%0d",
                   want.page_number, got.page_number, want.hit, got.hit,
                   want.slot, got.slot, want.fault_count, got.fault_count);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ADDR_W-1:0]     address_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ADDR_W-1:0]     page_number_o;
  logic                  hit_o;
  logic [SLOT_OUT_W-1:0] slot_o;
  logic [FAULT_W-1:0]    fault_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  frame_table_scoreboard sb = new();
  bit                    calm;
  int unsigned           cycle_count;

  fifo_page_replacement_core #(
    .MAX_FRAMES(FRAMES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .page_number_o(page_number_o),
    .hit_o        (hit_o),
    .slot_o       (slot_o),
    .fault_count_o(fault_count_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  // result side: values read right after the edge are the pre-edge ones,
  // so a transaction is exactly valid and ready seen together here
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.compare_lookup('{page_number_o, hit_o, slot_o, fault_count_o});
    // random backpressure, none during the calm phase
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one apb write: setup cycle, access cycle, then psel drops low again
  task automatic apb_write(reg_idx_e idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register taken at this edge since pready is tied high
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
    @(posedge clk_i);
  endtask

  // let every owed result come back, then let the core settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // config only changes with nothing in flight
  task automatic configure(logic [PDATA_W-1:0] size, logic [PDATA_W-1:0] count);
    drain();
    apb_write(REG_PAGE_SIZE, size);
    apb_write(REG_FRAME_COUNT, count);
  endtask

  // one address transaction, with an optional idle gap in front of it;
  // the gap runs while the core is ready so that it is actually seen
  task automatic send_address(logic [ADDR_W-1:0] address);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < IDLE_PCT) ? $urandom_range(MAX_GAP, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!in_ready_o);
      repeat (gap - 1) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= address;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_address(address);
  endtask

  // mostly a small working set of pages around base_page so that hits,
  // faults and wrap-around of the fifo pointer all happen; the rest is noise
  function automatic logic [ADDR_W-1:0] pick_address(int unsigned base_page);
    longint unsigned divisor;
    longint unsigned page;
    longint unsigned addr;
    int unsigned     roll;
    divisor = (sb.page_size == 0) ? 1 : sb.page_size;
    roll = $urandom_range(99);
    if (roll < 75) begin
      page = base_page + $urandom_range(sb.frames_active() + 3);
      addr = page * divisor + $urandom_range(int'(divisor - 1));
      if (addr > MAX_ADDR) addr = $urandom & MAX_ADDR;
    end else if (roll < 88) begin
      addr = $urandom & MAX_ADDR;
    end else if (roll < 94) begin
      addr = MAX_ADDR - $urandom_range(15);
    end else begin
      addr = $urandom_range(15);
    end
    return addr[ADDR_W-1:0];
  endfunction

  initial begin
    logic [PDATA_W-1:0] size;
    logic [PDATA_W-1:0] count;
    longint unsigned    divisor;
    int unsigned        base_page;
    int unsigned        roll;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    address_i   = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    calm        = 1'b0;
    cycle_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: extremes of the address, a hit within a page
    send_address('0);
    send_address(ADDR_W'(MAX_ADDR));
    send_address(ADDR_W'(4095));
    send_address(ADDR_W'(4096));
    send_address(ADDR_W'(8191));

    // page size zero acts as one, frame count zero as one frame;
    // the pointer is past the single frame so the fault restarts at zero
    configure(0, 0);
    send_address(ADDR_W'(5));
    send_address(ADDR_W'(5));
    send_address(ADDR_W'(7));
    send_address(ADDR_W'(1));

    // grow back to 16: page 1 sits in frames 0 and 2, lowest one reported
    configure(1, 16);
    send_address(ADDR_W'(1));
    send_address(ADDR_W'(7));

    // largest page size, frame count above the table depth saturates
    configure(PAGE_SIZE_MAX, (1 << FCNT_W) - 1);
    send_address(ADDR_W'(MAX_ADDR));
    send_address(ADDR_W'(PAGE_SIZE_MAX));
    send_address('0);

    // shrink below the pointer: next fault goes to frame zero
    configure(1 << 20, 2);
    send_address('0);
    send_address(ADDR_W'(MAX_ADDR));
    send_address(ADDR_W'((1 << 20) - 1));

    // random phases, each with its own config
    for (int phase = 0; phase < PHASES; phase++) begin
      roll = $urandom_range(99);
      if (roll < 10)      size = 0;
      else if (roll < 20) size = 1;
      else if (roll < 30) size = PAGE_SIZE_MAX;
      else if (roll < 40) size = 1 << 20;
      else if (roll < 70) size = $urandom_range(4096, 2);
      else                size = $urandom_range(PAGE_SIZE_MAX, 1);
      // bits above the register width are dropped by the core
      if ($urandom_range(4) == 0) size = size | ($urandom << PSIZE_W);
      roll = $urandom_range(99);
      if (roll < 10)      count = 0;
      else if (roll < 20) count = $urandom_range((1 << FCNT_W) - 1, FRAMES + 1);
      else if (roll < 30) count = 1;
      else                count = $urandom_range(FRAMES, 2);
      if ($urandom_range(4) == 0) count = count | ($urandom << FCNT_W);
      configure(size, count);

      calm = (phase == CALM_PHASE);
      divisor = (sb.page_size == 0) ? 1 : sb.page_size;
      base_page = ($urandom_range(1) != 0) ? 0 : $urandom_range(int'(MAX_ADDR / divisor));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // move the working set now and then so old pages age out
        if ($urandom_range(49) == 0)
          base_page = $urandom_range(int'(MAX_ADDR / divisor));
        send_address(pick_address(base_page));
      end
      calm = 1'b0;
    end

    drain();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
